>>> src/set_assoc_lru_cache_core_assert.svh
// Assertion macros for the cache core.
// Used by set_assoc_lru_cache_core; no other dependencies.
`ifndef SET_ASSOC_LRU_CACHE_CORE_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SALC_ASSERT_CLK(lbl, c, r, p) \
  lbl: assert property (@(posedge c) disable iff (r) p) else $error("cache check failed");
`define SALC_ASSERT(lbl, p) `SALC_ASSERT_CLK(lbl, clk, rst, p)
`else
`define SALC_ASSERT_CLK(lbl, c, r, p)
`define SALC_ASSERT(lbl, p)
`endif
`endif

>>> src/salc_pkg.sv
// Shared types and constants for the set-associative cache core.
// No dependencies.
`default_nettype none
package salc_pkg;
  localparam int ADDR_W    = 12;
  localparam int WORD_W    = 32;
  localparam int STAMP_W   = 32;
  localparam int WAY_MAX_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 1;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOCATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK     = 1'b1;

  typedef struct packed {
    logic                 hit;
    logic [WAY_MAX_W-1:0] hit_way;
    logic [WAY_MAX_W-1:0] vic_way;
    logic                 vic_dirty;
  } lookup_t;
endpackage
`default_nettype wire

>>> src/salc_req_if.sv
// Request channel: one word access per handshake.
// Depends on salc_pkg.
`default_nettype none
interface salc_req_if import salc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [ADDR_W-1:0] word_address;
  logic [WORD_W-1:0] write_value;
  modport source (output valid, action, word_address, write_value, input ready);
  modport sink   (input valid, action, word_address, write_value, output ready);
endinterface
`default_nettype wire

>>> src/salc_rsp_if.sv
// Response channel: one result word per access.
// Depends on salc_pkg.
`default_nettype none
interface salc_rsp_if import salc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] read_value;
  logic              was_hit;
  logic              did_writeback;
  logic [WORD_W-1:0] hit_total;
  modport source (output valid, read_value, was_hit, did_writeback, hit_total, input ready);
  modport sink   (input valid, read_value, was_hit, did_writeback, hit_total, output ready);
endinterface
`default_nettype wire

>>> src/salc_victim.sv
// Tag match and LRU victim pick over one set row.
// Depends on salc_pkg.
`default_nettype none
module salc_victim import salc_pkg::*; #(
  parameter int NUM_WAYS = 4,
  parameter int TAG_W    = 6
) (
  input  wire logic [NUM_WAYS-1:0][TAG_W-1:0]   tags,
  input  wire logic [NUM_WAYS-1:0][STAMP_W-1:0] stamps,
  input  wire logic [NUM_WAYS-1:0]              valid,
  input  wire logic [NUM_WAYS-1:0]              dirty,
  input  wire logic [TAG_W-1:0]                 tag,
  output lookup_t                               lk
);
  localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

  always_comb begin
    logic               found_inv;
    logic [STAMP_W-1:0] best;
    lk        = '0;
    found_inv = 1'b0;
    best      = stamps[0];
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (valid[w] && tags[w] == tag) begin
        lk.hit     = 1'b1;
        lk.hit_way = WAY_MAX_W'(w);
      end
    end
    // first invalid way wins
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (!valid[w]) begin
        found_inv  = 1'b1;
        lk.vic_way = WAY_MAX_W'(w);
      end
    end
    if (!found_inv) begin
      lk.vic_way = '0;
      for (int w = 1; w < NUM_WAYS; w++) begin
        if (stamps[w] < best) begin
          best       = stamps[w];
          lk.vic_way = WAY_MAX_W'(w);
        end
      end
    end
    lk.vic_dirty = !found_inv && dirty[WAY_W'(lk.vic_way)];
  end
endmodule
`default_nettype wire

>>> src/set_assoc_lru_cache_core.sv
// Set-associative LRU cache core, write-back/through, over a backing word memory.
// Line walks (fill, writeback, write-through) copy WORDS_PER_LINE words between line and backing memory.
// Throughput: one word at a time; tag row read, line walks and write-through set the pace.
// Reset: synchronous; then clears backing memory word by word in S_CLEAR, no words accepted.
// Depends on salc_pkg, salc_req_if, salc_rsp_if, salc_victim, the assert header.
`default_nettype none
`include "set_assoc_lru_cache_core_assert.svh"
module set_assoc_lru_cache_core import salc_pkg::*; #(
  parameter int NUM_SETS       = 16,
  parameter int NUM_WAYS       = 4,
  parameter int WORDS_PER_LINE = 4,
  parameter int MEM_WORDS      = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  salc_req_if.sink                  req,
  salc_rsp_if.source                rsp,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);
  localparam int OFF_SH = $clog2(WORDS_PER_LINE);
  localparam int SET_SH = $clog2(NUM_SETS);
  localparam int OFF_W  = (WORDS_PER_LINE > 1) ? OFF_SH : 1;
  localparam int SET_W  = (NUM_SETS > 1) ? SET_SH : 1;
  localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int MEM_AW = $clog2(MEM_WORDS);
  localparam int TAG_W  = (MEM_AW - OFF_SH - SET_SH > 0) ? MEM_AW - OFF_SH - SET_SH : 1;
  localparam int LW_D   = NUM_SETS * NUM_WAYS * WORDS_PER_LINE;
  localparam int LW_AW  = (LW_D > 1) ? $clog2(LW_D) : 1;
  localparam int CNT_W  = $clog2(WORDS_PER_LINE + 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LOOKUP = 3'd2;
  localparam logic [2:0] S_COPY   = 3'd3;
  localparam logic [2:0] S_ACCESS = 3'd4;
  localparam logic [2:0] S_RDWAIT = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  // what follows a line walk
  localparam logic [1:0] AFT_FILL   = 2'd0;
  localparam logic [1:0] AFT_ACCESS = 2'd1;
  localparam logic [1:0] AFT_FINISH = 2'd2;

  logic [2:0] state;

  // config
  logic walloc, wback;
  always_ff @(posedge clk) begin
    if (rst) begin
      walloc <= 1'b1;
      wback  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WRITE_ALLOCATE: walloc <= cfg_data[0];
        CFG_WRITE_BACK:     wback  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // latched request
  logic              act;
  logic [MEM_AW-1:0] addr;
  logic [WORD_W-1:0] wval;
  logic [SET_W-1:0]  set_q;
  logic [TAG_W-1:0]  tag_q;
  logic [OFF_W-1:0]  off_q;
  logic [WAY_W-1:0]  way;
  logic              hit, wb, miss;

  logic [MEM_AW-1:0] in_addr;
  logic [SET_W-1:0]  in_set;
  assign in_addr = MEM_AW'(req.word_address);
  assign in_set  = SET_W'(in_addr >> OFF_SH);

  // set row memory: tag, dirty and stamp for every way of a set
  logic [NUM_WAYS-1:0][TAG_W-1:0]   rt_mem [NUM_SETS];
  logic [NUM_WAYS-1:0]              rd_mem [NUM_SETS];
  logic [NUM_WAYS-1:0][STAMP_W-1:0] rs_mem [NUM_SETS];
  logic [NUM_WAYS-1:0][TAG_W-1:0]   rt_q, r_tags, w_tags;
  logic [NUM_WAYS-1:0]              rd_q, r_dirty, w_dirty;
  logic [NUM_WAYS-1:0][STAMP_W-1:0] rs_q, r_stamps, w_stamps;
  logic                             row_we;

  always_ff @(posedge clk) begin
    if (row_we) begin
      rt_mem[set_q] <= w_tags;
      rd_mem[set_q] <= w_dirty;
      rs_mem[set_q] <= w_stamps;
    end
    rt_q <= rt_mem[in_set];
    rd_q <= rd_mem[in_set];
    rs_q <= rs_mem[in_set];
  end

  // valid bits in flops, cleared at reset
  logic [NUM_SETS-1:0][NUM_WAYS-1:0] valid;

  // line word memory (contents undefined until filled)
  logic [WORD_W-1:0] lw_mem [LW_D];
  logic [WORD_W-1:0] lw_q, lw_wd;
  logic [LW_AW-1:0]  lw_ra, lw_wa;
  logic              lw_we;
  always_ff @(posedge clk) begin
    if (lw_we) lw_mem[lw_wa] <= lw_wd;
    lw_q <= lw_mem[lw_ra];
  end

  // backing memory
  logic [WORD_W-1:0] bm_mem [MEM_WORDS];
  logic [WORD_W-1:0] bm_q, bm_wd;
  logic [MEM_AW-1:0] bm_ra, bm_wa;
  logic              bm_we;
  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_wa] <= bm_wd;
    bm_q <= bm_mem[bm_ra];
  end

  // line walk control
  logic              dir_in;   // 1: memory to line (fill), 0: line to memory
  logic [1:0]        aft;
  logic [TAG_W-1:0]  copy_tag;
  logic [CNT_W-1:0]  cnt;
  logic              pend;
  logic [OFF_W-1:0]  pidx;
  logic [MEM_AW-1:0] clr;
  logic [MEM_AW-1:0] base;
  logic              walk_left;

  assign base = MEM_AW'((int'(copy_tag) * NUM_SETS + int'(set_q)) * WORDS_PER_LINE);
  assign walk_left = (cnt < CNT_W'(WORDS_PER_LINE));

  function automatic logic [LW_AW-1:0] lw_idx(input logic [SET_W-1:0] s,
                                              input logic [WAY_W-1:0] w, input int o);
    return LW_AW'((int'(s) * NUM_WAYS + int'(w)) * WORDS_PER_LINE + o);
  endfunction

  // lookup works on the row as it comes out of the memory in S_LOOKUP
  lookup_t lk;
  salc_victim #(.NUM_WAYS(NUM_WAYS), .TAG_W(TAG_W)) u_victim (
    .tags(rt_q), .stamps(rs_q), .valid(valid[set_q]), .dirty(rd_q),
    .tag(tag_q), .lk(lk)
  );

  logic [STAMP_W-1:0] clock_cnt, hit_cnt;
  logic [WORD_W-1:0]  rd_val;
  logic               out_valid;
  logic [WORD_W-1:0]  o_rd, o_hits;
  logic               o_hit, o_wb;
  logic               in_acc, out_load;

  assign req.ready         = (state == S_IDLE);
  assign in_acc            = req.valid && req.ready;
  assign out_load          = (state == S_FINISH) && (!out_valid || rsp.ready);
  assign rsp.valid         = out_valid;
  assign rsp.read_value    = o_rd;
  assign rsp.was_hit       = o_hit;
  assign rsp.did_writeback = o_wb;
  assign rsp.hit_total     = o_hits;

  // row image written back in the access step
  always_comb begin
    w_tags   = r_tags;
    w_dirty  = r_dirty;
    w_stamps = r_stamps;
    w_tags[way]   = tag_q;
    w_stamps[way] = clock_cnt + 1'b1;
    w_dirty[way]  = (miss ? 1'b0 : r_dirty[way]) || (act == ACT_WRITE && wback);
  end
  assign row_we = (state == S_ACCESS);

  // memory port steering
  always_comb begin
    lw_ra = lw_idx(set_q, way, int'(cnt));
    lw_we = 1'b0;
    lw_wa = lw_idx(set_q, way, int'(pidx));
    lw_wd = bm_q;
    bm_ra = MEM_AW'(base + MEM_AW'(cnt));
    bm_we = 1'b0;
    bm_wa = MEM_AW'(base + MEM_AW'(pidx));
    bm_wd = lw_q;
    unique case (state)
      S_CLEAR: begin
        bm_we = 1'b1;
        bm_wa = clr;
        bm_wd = '0;
      end
      S_LOOKUP: begin
        if (!lk.hit && act == ACT_WRITE && !walloc) begin
          bm_we = 1'b1;
          bm_wa = addr;
          bm_wd = wval;
        end
      end
      S_COPY: begin
        lw_we = pend && dir_in;
        bm_we = pend && !dir_in;
      end
      S_ACCESS: begin
        lw_ra = lw_idx(set_q, way, int'(off_q));
        lw_wa = lw_idx(set_q, way, int'(off_q));
        lw_wd = wval;
        lw_we = (act == ACT_WRITE);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      valid     <= '0;
      clock_cnt <= '0;
      hit_cnt   <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      cnt       <= '0;
    end else begin
      // output word drains on ready unless a new one loads this cycle
      if (rsp.ready && !out_load) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == MEM_AW'(MEM_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            act   <= req.action;
            addr  <= in_addr;
            wval  <= req.write_value;
            set_q <= in_set;
            tag_q <= TAG_W'(in_addr >> (OFF_SH + SET_SH));
            off_q <= OFF_W'(in_addr & MEM_AW'(WORDS_PER_LINE - 1));
            hit   <= 1'b0;
            wb    <= 1'b0;
            miss  <= 1'b0;
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          r_tags   <= rt_q;
          r_dirty  <= rd_q;
          r_stamps <= rs_q;
          cnt      <= '0;
          pend     <= 1'b0;
          rd_val   <= '0;
          if (lk.hit) begin
            hit     <= 1'b1;
            hit_cnt <= hit_cnt + 1'b1;
            way     <= WAY_W'(lk.hit_way);
            state   <= S_ACCESS;
          end else if (act == ACT_WRITE && !walloc) begin
            state <= S_FINISH;
          end else begin
            miss <= 1'b1;
            way  <= WAY_W'(lk.vic_way);
            if (lk.vic_dirty) begin
              wb       <= 1'b1;
              dir_in   <= 1'b0;
              copy_tag <= rt_q[WAY_W'(lk.vic_way)];
              aft      <= AFT_FILL;
            end else begin
              dir_in   <= 1'b1;
              copy_tag <= tag_q;
              aft      <= AFT_ACCESS;
            end
            state <= S_COPY;
          end
        end
        S_COPY: begin
          // issue one read a cycle, commit it the next
          pend <= walk_left;
          pidx <= OFF_W'(cnt);
          if (walk_left) cnt <= cnt + 1'b1;
          if (!walk_left && !pend) begin
            cnt <= '0;
            unique case (aft)
              AFT_FILL: begin
                dir_in   <= 1'b1;
                copy_tag <= tag_q;
                aft      <= AFT_ACCESS;
              end
              AFT_ACCESS: state <= S_ACCESS;
              default:    state <= S_FINISH;
            endcase
          end
        end
        S_ACCESS: begin
          valid[set_q][way] <= 1'b1;
          clock_cnt         <= clock_cnt + 1'b1;
          if (act == ACT_READ) begin
            state <= S_RDWAIT;
          end else if (!wback) begin
            dir_in   <= 1'b0;
            copy_tag <= tag_q;
            aft      <= AFT_FINISH;
            cnt      <= '0;
            pend     <= 1'b0;
            state    <= S_COPY;
          end else begin
            state <= S_FINISH;
          end
        end
        S_RDWAIT: begin
          rd_val <= lw_q;
          state  <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) begin
            out_valid <= 1'b1;
            o_rd      <= rd_val;
            o_hit     <= hit;
            o_wb      <= wb;
            o_hits    <= hit_cnt;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `SALC_ASSERT(a_accept_idle, in_acc |=> state == S_LOOKUP)
  `SALC_ASSERT(a_out_from_finish, $rose(out_valid) |-> $past(state) == S_FINISH)
  `SALC_ASSERT(a_hits_step, hit_cnt != $past(hit_cnt) |-> $past(state) == S_LOOKUP)
  `SALC_ASSERT(a_no_mem_write_idle, state == S_IDLE |-> !bm_we && !lw_we && !row_we)
endmodule
`default_nettype wire
